### design/pfgp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the grid partition block
package pfgp_pkg;

    localparam int SIZE_W  = 16;
    localparam int PROC_W  = 16;
    localparam int DIMS    = 4;
    localparam int IDX_W   = 2;
    localparam int STEN_W  = 8;
    localparam logic [STEN_W-1:0] STEN_RESET = 8'd5;
    localparam int DIV_W   = 16;
    localparam int CNT_W   = 5;
    // trial divisor never passes 256, since 256*256 exceeds any 16-bit value
    localparam int TD_W    = 9;
    localparam int IN_W    = PROC_W + DIMS * SIZE_W;
    localparam int OUT_W   = 136;

    typedef enum logic [1:0] {
        DIV_QUOT,
        DIV_TRIAL,
        DIV_ZONE
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP_MUL,
        ST_CMP_SEL,
        ST_QDIV_START,
        ST_QDIV_WAIT,
        ST_TRIAL_CHECK,
        ST_TDIV_START,
        ST_TDIV_WAIT,
        ST_APPLY,
        ST_ZDIV_START,
        ST_ZDIV_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     cmp_init;
        logic     cmp_mul;
        logic     cmp_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     q_load;
        logic     trial_upd;
        logic     apply;
        logic     zone_init;
        logic     zone_store;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic idx_last;
        logic div_done;
        logic sq_le;
        logic out_busy;
    } status_t;

endpackage

### design/pfgp_div.sv
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle
module pfgp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfgp_pkg::DIV_W-1:0]  dividend,
    input  logic [pfgp_pkg::DIV_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [pfgp_pkg::DIV_W-1:0]  quot,
    output logic [pfgp_pkg::DIV_W-1:0]  rem
);

    logic [pfgp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pfgp_pkg::DIV_W-1:0] q_reg, q_next;
    logic [pfgp_pkg::DIV_W:0]   r_reg, r_next;
    logic [pfgp_pkg::DIV_W-1:0] dvs_reg, dvs_next;
    logic [pfgp_pkg::DIV_W:0]   shifted;
    logic                       fit;

    assign shifted = {r_reg[pfgp_pkg::DIV_W-1:0], q_reg[pfgp_pkg::DIV_W-1]};
    assign fit     = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next = fit ? (shifted - {1'b0, dvs_reg}) : shifted;
            q_next = {q_reg[pfgp_pkg::DIV_W-2:0], fit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pfgp_pkg::CNT_W'(pfgp_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[pfgp_pkg::DIV_W-1:0];

endmodule

### design/pfgp_datapath.sv
`timescale 1ns / 1ps
// datapath: operand registers, ratio compare, factor search and output register
module pfgp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfgp_pkg::cmd_t               cmd,
    output pfgp_pkg::status_t            sts,
    input  logic                         cfg_we,
    input  logic [pfgp_pkg::STEN_W-1:0]  cfg_wdata,
    input  logic [pfgp_pkg::IN_W-1:0]    in_data,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pfgp_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [pfgp_pkg::STEN_W-1:0] sten_reg;
    logic [pfgp_pkg::PROC_W-1:0] procs_reg, used_reg;
    logic [pfgp_pkg::SIZE_W-1:0] size_reg  [pfgp_pkg::DIMS];
    logic [pfgp_pkg::PROC_W-1:0] parts_reg [pfgp_pkg::DIMS];
    logic [pfgp_pkg::SIZE_W-1:0] zones_reg [pfgp_pkg::DIMS];
    logic [pfgp_pkg::DIMS-1:0]   mask_reg;
    logic [pfgp_pkg::IDX_W-1:0]  idx_reg, best_reg;
    logic [pfgp_pkg::SIZE_W-1:0] best_size_reg;
    logic [pfgp_pkg::PROC_W-1:0] best_parts_reg;
    logic [pfgp_pkg::SIZE_W+pfgp_pkg::PROC_W-1:0] lhs_reg, rhs_reg;
    logic [pfgp_pkg::DIV_W-1:0]  r_reg;
    logic [pfgp_pkg::TD_W-1:0]   d_reg;
    logic                        out_valid_reg;
    logic [pfgp_pkg::OUT_W-1:0]  out_reg;

    logic [pfgp_pkg::DIV_W-1:0]  dv_a, dv_b, dv_q, dv_r;
    logic                        dv_busy, dv_done;
    logic [pfgp_pkg::SIZE_W-1:0] cur_size;
    logic [pfgp_pkg::PROC_W-1:0] cur_parts;
    logic                        take;
    logic [2*pfgp_pkg::TD_W-1:0] d_sq;
    logic                        fits;

    assign cur_size  = size_reg[idx_reg];
    assign cur_parts = parts_reg[idx_reg];
    assign d_sq      = d_reg * d_reg;

    assign take = (lhs_reg > rhs_reg) ||
                  ((lhs_reg == rhs_reg) && (cur_size > cur_parts) &&
                   (cur_parts < best_parts_reg));

    always_comb
    begin
        case (cmd.div_sel)
            pfgp_pkg::DIV_QUOT:
            begin
                dv_a = procs_reg;
                dv_b = used_reg;
            end
            pfgp_pkg::DIV_TRIAL:
            begin
                dv_a = r_reg;
                dv_b = pfgp_pkg::DIV_W'(d_reg);
            end
            pfgp_pkg::DIV_ZONE:
            begin
                dv_a = cur_size;
                dv_b = cur_parts;
            end
            default:
            begin
                dv_a = procs_reg;
                dv_b = used_reg;
            end
        endcase
    end

    pfgp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .busy     (dv_busy),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sten_reg <= pfgp_pkg::STEN_RESET;
        else if (cfg_we)
            sten_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            procs_reg <= in_data[pfgp_pkg::PROC_W-1:0];
            used_reg  <= pfgp_pkg::PROC_W'(1);
            for (int k = 0; k < pfgp_pkg::DIMS; k++)
            begin
                size_reg[k]  <= in_data[pfgp_pkg::PROC_W + k*pfgp_pkg::SIZE_W +:
                                        pfgp_pkg::SIZE_W];
                parts_reg[k] <= pfgp_pkg::PROC_W'(1);
            end
        end
        if (cmd.cmp_init)
        begin
            idx_reg        <= pfgp_pkg::IDX_W'(1);
            best_reg       <= '0;
            best_size_reg  <= size_reg[0];
            best_parts_reg <= parts_reg[0];
        end
        if (cmd.cmp_mul)
        begin
            lhs_reg <= cur_size * best_parts_reg;
            rhs_reg <= best_size_reg * cur_parts;
        end
        if (cmd.cmp_sel)
        begin
            if (take)
            begin
                best_reg       <= idx_reg;
                best_size_reg  <= cur_size;
                best_parts_reg <= cur_parts;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.q_load)
        begin
            r_reg <= dv_q;
            d_reg <= pfgp_pkg::TD_W'(2);
        end
        if (cmd.trial_upd)
        begin
            if (dv_r == '0)
                r_reg <= dv_q;
            else
                d_reg <= d_reg + 1'b1;
        end
        if (cmd.apply)
        begin
            parts_reg[best_reg] <= pfgp_pkg::PROC_W'(best_parts_reg * r_reg);
            used_reg            <= pfgp_pkg::PROC_W'(used_reg * r_reg);
        end
        if (cmd.zone_init)
            idx_reg <= '0;
        if (cmd.zone_store)
        begin
            zones_reg[idx_reg] <= dv_q;
            mask_reg[idx_reg]  <= (dv_r != '0);
            idx_reg            <= idx_reg + 1'b1;
        end
        if (cmd.out_load)
            out_reg <= {3'b000, fits, mask_reg,
                        zones_reg[3], zones_reg[2], zones_reg[1], zones_reg[0],
                        parts_reg[3], parts_reg[2], parts_reg[1], parts_reg[0]};
    end

    always_comb
    begin
        fits = 1'b1;
        for (int k = 0; k < pfgp_pkg::DIMS; k++)
            if (zones_reg[k] < pfgp_pkg::SIZE_W'(sten_reg))
                fits = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign sts.more     = used_reg < procs_reg;
    assign sts.idx_last = idx_reg == pfgp_pkg::IDX_W'(pfgp_pkg::DIMS - 1);
    assign sts.div_done = dv_done;
    assign sts.sq_le    = d_sq <= (2*pfgp_pkg::TD_W)'(r_reg);
    assign sts.out_busy = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !m_axis_tready))
        else $error("result register overwritten");

    // the divider is only started when it is free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !dv_busy)
        else $error("divider started while busy");

    // every factor applied is a real factor
    a_factor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (r_reg >= pfgp_pkg::DIV_W'(2)))
        else $error("applied factor below two");

endmodule

### design/pfgp_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the partition search
module pfgp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfgp_pkg::status_t  sts,
    output pfgp_pkg::cmd_t     cmd
);

    pfgp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfgp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfgp_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pfgp_pkg::ST_CHECK;
            pfgp_pkg::ST_CHECK:
                state_next = sts.more ? pfgp_pkg::ST_CMP_MUL : pfgp_pkg::ST_ZDIV_START;
            pfgp_pkg::ST_CMP_MUL:
                state_next = pfgp_pkg::ST_CMP_SEL;
            pfgp_pkg::ST_CMP_SEL:
                state_next = sts.idx_last ? pfgp_pkg::ST_QDIV_START : pfgp_pkg::ST_CMP_MUL;
            pfgp_pkg::ST_QDIV_START:
                state_next = pfgp_pkg::ST_QDIV_WAIT;
            pfgp_pkg::ST_QDIV_WAIT:
                if (sts.div_done)
                    state_next = pfgp_pkg::ST_TRIAL_CHECK;
            pfgp_pkg::ST_TRIAL_CHECK:
                state_next = sts.sq_le ? pfgp_pkg::ST_TDIV_START : pfgp_pkg::ST_APPLY;
            pfgp_pkg::ST_TDIV_START:
                state_next = pfgp_pkg::ST_TDIV_WAIT;
            pfgp_pkg::ST_TDIV_WAIT:
                if (sts.div_done)
                    state_next = pfgp_pkg::ST_TRIAL_CHECK;
            pfgp_pkg::ST_APPLY:
                state_next = pfgp_pkg::ST_CHECK;
            pfgp_pkg::ST_ZDIV_START:
                state_next = pfgp_pkg::ST_ZDIV_WAIT;
            pfgp_pkg::ST_ZDIV_WAIT:
                if (sts.div_done)
                    state_next = sts.idx_last ? pfgp_pkg::ST_FINISH : pfgp_pkg::ST_ZDIV_START;
            pfgp_pkg::ST_FINISH:
                if (!sts.out_busy)
                    state_next = pfgp_pkg::ST_IDLE;
            default:
                state_next = pfgp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = pfgp_pkg::DIV_QUOT;
        in_ready    = 1'b0;
        case (state_reg)
            pfgp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pfgp_pkg::ST_CHECK:
            begin
                cmd.cmp_init  = sts.more;
                cmd.zone_init = !sts.more;
            end
            pfgp_pkg::ST_CMP_MUL:
                cmd.cmp_mul = 1'b1;
            pfgp_pkg::ST_CMP_SEL:
                cmd.cmp_sel = 1'b1;
            pfgp_pkg::ST_QDIV_START:
                cmd.div_start = 1'b1;
            pfgp_pkg::ST_QDIV_WAIT:
                cmd.q_load = sts.div_done;
            pfgp_pkg::ST_TRIAL_CHECK:
                cmd.div_sel = pfgp_pkg::DIV_TRIAL;
            pfgp_pkg::ST_TDIV_START:
            begin
                cmd.div_sel   = pfgp_pkg::DIV_TRIAL;
                cmd.div_start = 1'b1;
            end
            pfgp_pkg::ST_TDIV_WAIT:
            begin
                cmd.div_sel   = pfgp_pkg::DIV_TRIAL;
                cmd.trial_upd = sts.div_done;
            end
            pfgp_pkg::ST_APPLY:
                cmd.apply = 1'b1;
            pfgp_pkg::ST_ZDIV_START:
            begin
                cmd.div_sel   = pfgp_pkg::DIV_ZONE;
                cmd.div_start = 1'b1;
            end
            pfgp_pkg::ST_ZDIV_WAIT:
            begin
                cmd.div_sel    = pfgp_pkg::DIV_ZONE;
                cmd.zone_store = sts.div_done;
            end
            pfgp_pkg::ST_FINISH:
                cmd.out_load = !sts.out_busy;
            default:
                cmd = '0;
        endcase
    end

    // a transaction is only taken while no item is being worked on
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == pfgp_pkg::ST_CHECK)
        else $error("load outside idle");

    // the divider result is consumed only in a wait state
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.q_load || cmd.trial_upd || cmd.zone_store) |-> sts.div_done)
        else $error("divider result used before done");

    // a result is loaded once per item, then the block returns to idle
    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == pfgp_pkg::ST_IDLE)
        else $error("result load not followed by idle");

endmodule

### design/prime_factor_grid_partition.sv
`timescale 1ns / 1ps
// top level: splits a processor count over four grid dimensions
//
// input stream s_axis carries one request per transaction: processor count and
// four grid sizes. output stream m_axis carries one result per request: parts
// and smallest zone count per dimension, uneven mask and fits flag.
// stencil_width is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce this. one request is worked on at a time.
// each factor costs a ratio compare for each of the three dimensions after
// the first, a divide for the remaining count, then one trial step per
// candidate divisor up to the square root; the divides all go through one
// shared serial divider, and the end adds four zone divides.
// a finished result sits in an output register; the next request is taken
// while it waits, and only the final hand-over waits on a stalled receiver.
// reset clears the control state and sets stencil_width to 5.
module prime_factor_grid_partition (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pfgp_pkg::STEN_W-1:0]  cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // proc_count, size_x, size_y, size_vx, size_vy
    input  logic [pfgp_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // parts_x, parts_y, parts_vx, parts_vy, zones_x, zones_y, zones_vx,
    // zones_vy, uneven_mask, fits, zero fill
    output logic [pfgp_pkg::OUT_W-1:0]   m_axis_tdata
);

    pfgp_pkg::cmd_t    cmd;
    pfgp_pkg::status_t sts;

    pfgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfgp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_data       (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### test/prime_factor_grid_partition_check.sv
`timescale 1ns / 1ps
// checker: watches both streams, predicts each partition result and compares
module prime_factor_grid_partition_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pfgp_pkg::STEN_W-1:0] cfg_wdata,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [pfgp_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [pfgp_pkg::OUT_W-1:0]  m_axis_tdata,
    output int                          errors,
    output int                          pending
);
    import pfgp_pkg::*;

    typedef struct {
        logic [15:0] parts [DIMS];
        logic [15:0] zones [DIMS];
        logic [3:0]  uneven;
        logic        fits;
    } split_t;

    split_t       split_q [$];
    logic [7:0]   stencil;

    function automatic longint unsigned top_prime(longint unsigned r);
        longint unsigned d;
        d = 2;
        while (d * d <= r)
        begin
            if (r % d == 0 && r != d)
                r = r / d;
            else
                d++;
        end
        return r;
    endfunction

    function automatic split_t split_grid(logic [IN_W-1:0] req, logic [7:0] sw);
        split_t          res;
        longint unsigned procs, used, f, lhs, rhs;
        longint unsigned sz [DIMS];
        longint unsigned pt [DIMS];
        int              best;
        procs = req[15:0];
        used = 1;
        res.uneven = '0;
        res.fits = 1'b1;
        for (int i = 0; i < DIMS; i++)
        begin
            sz[i] = req[16*(i+1) +: 16];
            pt[i] = 1;
        end
        while (used < procs)
        begin
            best = 0;
            for (int i = 1; i < DIMS; i++)
            begin
                lhs = sz[i] * pt[best];
                rhs = sz[best] * pt[i];
                // on equal ratio above one, fewer parts wins
                if (lhs > rhs || (lhs == rhs && sz[i] > pt[i] && pt[i] < pt[best]))
                    best = i;
            end
            f = top_prime(procs / used);
            pt[best] *= f;
            used *= f;
        end
        for (int i = 0; i < DIMS; i++)
        begin
            res.parts[i] = pt[i][15:0];
            res.zones[i] = 16'(sz[i] / pt[i]);
            res.uneven[i] = (sz[i] % pt[i]) != 0;
            if (sz[i] / pt[i] < sw)
                res.fits = 1'b0;
        end
        return res;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
    end

    assign pending = split_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        split_t want;
        if (!rst_n)
        begin
            stencil <= STEN_RESET;
        end
        else
        begin
            if (cfg_we)
                stencil <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                split_q.push_back(split_grid(s_axis_tdata, stencil));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (split_q.size() == 0)
                begin
                    report("unexpected transaction", 1, 0);
                end
                else
                begin
                    want = split_q.pop_front();
                    for (int i = 0; i < DIMS; i++)
                    begin
                        if (m_axis_tdata[16*i +: 16] !== want.parts[i])
                            report($sformatf("parts[%0d]", i), m_axis_tdata[16*i +: 16],
                                   want.parts[i]);
                        if (m_axis_tdata[64 + 16*i +: 16] !== want.zones[i])
                            report($sformatf("zones[%0d]", i), m_axis_tdata[64 + 16*i +: 16],
                                   want.zones[i]);
                    end
                    if (m_axis_tdata[131:128] !== want.uneven)
                        report("uneven_mask", m_axis_tdata[131:128], want.uneven);
                    if (m_axis_tdata[132] !== want.fits)
                        report("fits", m_axis_tdata[132], want.fits);
                end
            end
        end
    end

endmodule

### test/prime_factor_grid_partition_test.sv
`timescale 1ns / 1ps
// testbench top: drives requests and config, stalls the receiver, gives the verdict
module prime_factor_grid_partition_test;
    import pfgp_pkg::*;

    localparam longint LIMIT = 8_000_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STEN_W-1:0]  cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    int                 errors;
    int                 pending;
    logic               no_idle;
    longint             cycles;

    prime_factor_grid_partition u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    prime_factor_grid_partition_check u_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    task automatic send_request(logic [15:0] procs, logic [15:0] sx, logic [15:0] sy,
                                logic [15:0] svx, logic [15:0] svy);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {svy, svx, sy, sx, procs};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!no_idle && $urandom_range(0, 99) < 34)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_stencil(logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_procs();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 16'($urandom_range(0, 255));
        else if (sel < 88)
            return 16'($urandom_range(256, 4095));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] rand_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 16'($urandom_range(0, 65535));
        else if (sel < 80)
            return 16'($urandom_range(0, 80));
        return 16'd1 << $urandom_range(0, 15);
    endfunction

    task automatic random_burst(int n);
        logic [15:0] s;
        for (int k = 0; k < n; k++)
        begin
            // equal sizes exercise the tie rule
            if ($urandom_range(0, 99) < 20)
            begin
                s = rand_size();
                send_request(rand_procs(), s, s, s, s);
            end
            else
            begin
                send_request(rand_procs(), rand_size(), rand_size(), rand_size(),
                             rand_size());
            end
        end
    endtask

    initial
    begin
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset stencil width
        send_request(16'd0, 16'd64, 16'd64, 16'd64, 16'd64);
        send_request(16'd1, 16'd100, 16'd3, 16'd0, 16'd65535);
        send_request(16'd2, 16'd10, 16'd10, 16'd10, 16'd10);
        send_request(16'd4, 16'd1, 16'd1, 16'd1, 16'd1);
        send_request(16'd6, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(16'd12, 16'd0, 16'd40, 16'd0, 16'd0);
        send_request(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_request(16'd65521, 16'd65535, 16'd100, 16'd7, 16'd1);
        send_request(16'd64512, 16'd1000, 16'd500, 16'd250, 16'd125);
        send_request(16'd30030, 16'd3000, 16'd3000, 16'd30, 16'd30);
        send_request(16'd256, 16'd32, 16'd32, 16'd16, 16'd16);
        send_request(16'd49, 16'd35, 16'd35, 16'd70, 16'd5);
        write_stencil(8'd0);
        send_request(16'd64, 16'd2, 16'd3, 16'd0, 16'd1);
        send_request(16'd9, 16'd1, 16'd1, 16'd1, 16'd1);
        write_stencil(8'd255);
        send_request(16'd1, 16'd255, 16'd255, 16'd255, 16'd255);
        send_request(16'd1, 16'd255, 16'd254, 16'd255, 16'd255);
        write_stencil(8'd1);
        send_request(16'd8, 16'd8, 16'd8, 16'd8, 16'd7);

        // random phases, one without any idling
        random_burst(80);
        write_stencil(8'd5);
        no_idle = 1'b1;
        random_burst(60);
        no_idle = 1'b0;
        write_stencil(8'($urandom_range(0, 255)));
        random_burst(80);
        write_stencil(8'd2);
        random_burst(80);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/pfgp_pkg.sv
design/pfgp_div.sv
design/pfgp_datapath.sv
design/pfgp_ctrl.sv
design/prime_factor_grid_partition.sv
test/prime_factor_grid_partition_check.sv
test/prime_factor_grid_partition_test.sv
